[rtl/positional_insert_delete_store_top_defines.svh]
// Assertion macros shared by the positional insert/delete store RTL.
`ifndef POSITIONAL_INSERT_DELETE_STORE_TOP_DEFINES_SVH
`define POSITIONAL_INSERT_DELETE_STORE_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define PIDS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define PIDS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define PIDS_ASSERT(lbl, prop, msg)
`define PIDS_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

[rtl/pids_pkg.sv]
// Types and constants of the positional insert/delete store.
`timescale 1ns / 1ps
package pids_pkg;

  localparam int unsigned Capacity = 16;
  localparam int unsigned AddrW    = $clog2(Capacity);
  localparam int unsigned CntW     = $clog2(Capacity + 1);
  localparam int unsigned PosW     = 4;
  localparam int unsigned CmpW     = (CntW > PosW) ? CntW : PosW;
  localparam int unsigned ValW     = 32;
  localparam int unsigned OutCntW  = 5;

  typedef logic [AddrW-1:0]  addr_t;
  typedef logic [CntW-1:0]   cnt_t;
  typedef logic [CmpW-1:0]   cmp_t;
  typedef logic [ValW-1:0]   val_t;

  typedef enum logic [1:0] {
    OpInsert = 2'd0,
    OpAppend = 2'd1,
    OpDelete = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    StDone  = 2'd0,
    StFull  = 2'd1,
    StRange = 2'd2
  } status_e;

  typedef struct packed {
    status_e              status;
    logic [ValW-1:0]      removed;
    logic [OutCntW-1:0]   count;
    logic [ValW-1:0]      total;
  } res_t;

endpackage

[rtl/pids_ram.sv]
// Simple dual-port synchronous RAM with one write and one registered read port.
`timescale 1ns / 1ps
module pids_ram #(
  parameter int unsigned Depth = 16,
  parameter int unsigned Width = 32
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [$clog2(Depth)-1:0]   waddr_i,
  input  logic [Width-1:0]           wdata_i,
  input  logic                       re_i,
  input  logic [$clog2(Depth)-1:0]   raddr_i,
  output logic [Width-1:0]           rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/pids_ctrl.sv]
// Sequencer that decodes a request and shifts list entries through the RAM.
`timescale 1ns / 1ps
`include "positional_insert_delete_store_top_defines.svh"
module pids_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [1:0]              operation_i,
  input  logic [pids_pkg::PosW-1:0] position_i,
  input  logic [pids_pkg::ValW-1:0] value_i,
  output logic                    res_valid_o,
  input  logic                    res_ready_i,
  output pids_pkg::res_t          res_o,
  output logic                    mem_we_o,
  output pids_pkg::addr_t         mem_waddr_o,
  output pids_pkg::val_t          mem_wdata_o,
  output logic                    mem_re_o,
  output pids_pkg::addr_t         mem_raddr_o,
  input  pids_pkg::val_t          mem_rdata_i
);
  import pids_pkg::*;

  typedef enum logic [2:0] {
    SIdle,
    SShift,
    SPlace,
    SDelRead,
    SDelShift,
    SFinish
  } state_e;

  state_e  state_q, state_d;
  cnt_t    cnt_q, cnt_d;
  val_t    sum_q, sum_d;
  addr_t   pos_q, pos_d;
  addr_t   idx_q, idx_d;
  val_t    val_q, val_d;
  val_t    removed_q, removed_d;
  status_e status_q, status_d;
  cmp_t    pos_ext;
  cmp_t    cnt_ext;

  assign pos_ext = cmp_t'(position_i);
  assign cnt_ext = cmp_t'(cnt_q);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    sum_d       = sum_q;
    pos_d       = pos_q;
    idx_d       = idx_q;
    val_d       = val_q;
    removed_d   = removed_q;
    status_d    = status_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = '0;
    mem_wdata_o = '0;
    mem_re_o    = 1'b0;
    mem_raddr_o = '0;
    res_valid_o = 1'b0;

    unique case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          removed_d = '0;
          val_d     = value_i;
          pos_d     = addr_t'(position_i);
          status_d  = StDone;
          unique case (operation_i) inside
            OpInsert, OpAppend: begin
              if (cnt_q >= cnt_t'(Capacity)) begin
                status_d = StFull;
                state_d  = SFinish;
              end else if (operation_i == OpInsert && pos_ext > cnt_ext) begin
                status_d = StRange;
                state_d  = SFinish;
              end else if (operation_i == OpInsert && pos_ext != cnt_ext) begin
                mem_re_o    = 1'b1;
                mem_raddr_o = addr_t'(cnt_q - cnt_t'(1));
                idx_d       = addr_t'(cnt_q - cnt_t'(1));
                state_d     = SShift;
              end else begin
                pos_d   = addr_t'(cnt_q);
                state_d = SPlace;
              end
            end
            OpDelete: begin
              if (pos_ext >= cnt_ext) begin
                status_d = StRange;
                state_d  = SFinish;
              end else begin
                mem_re_o    = 1'b1;
                mem_raddr_o = addr_t'(position_i);
                state_d     = SDelRead;
              end
            end
            default: begin
              state_d = SFinish;
            end
          endcase
        end
      end
      SShift: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = idx_q + addr_t'(1);
        mem_wdata_o = mem_rdata_i;
        if (idx_q == pos_q) begin
          state_d = SPlace;
        end else begin
          mem_re_o    = 1'b1;
          mem_raddr_o = idx_q - addr_t'(1);
          idx_d       = idx_q - addr_t'(1);
        end
      end
      SPlace: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = pos_q;
        mem_wdata_o = val_q;
        cnt_d       = cnt_q + cnt_t'(1);
        sum_d       = sum_q + val_q;
        status_d    = StDone;
        state_d     = SFinish;
      end
      SDelRead: begin
        removed_d = mem_rdata_i;
        sum_d     = sum_q - mem_rdata_i;
        if (cnt_t'(pos_q) + cnt_t'(1) == cnt_q) begin
          cnt_d   = cnt_q - cnt_t'(1);
          state_d = SFinish;
        end else begin
          mem_re_o    = 1'b1;
          mem_raddr_o = pos_q + addr_t'(1);
          idx_d       = pos_q + addr_t'(1);
          state_d     = SDelShift;
        end
      end
      SDelShift: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = idx_q - addr_t'(1);
        mem_wdata_o = mem_rdata_i;
        if (cnt_t'(idx_q) + cnt_t'(1) == cnt_q) begin
          cnt_d   = cnt_q - cnt_t'(1);
          state_d = SFinish;
        end else begin
          mem_re_o    = 1'b1;
          mem_raddr_o = idx_q + addr_t'(1);
          idx_d       = idx_q + addr_t'(1);
        end
      end
      SFinish: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      cnt_q   <= '0;
      sum_q   <= '0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      sum_q     <= sum_d;
      pos_q     <= pos_d;
      idx_q     <= idx_d;
      val_q     <= val_d;
      removed_q <= removed_d;
      status_q  <= status_d;
    end
  end

  assign in_ready_o     = (state_q == SIdle);
  assign res_o.status   = status_q;
  assign res_o.removed  = removed_q;
  assign res_o.count    = OutCntW'(cnt_q);
  assign res_o.total    = sum_q;

  `PIDS_ASSERT(a_cnt_bound, cnt_q <= cnt_t'(Capacity), "Entry count exceeds capacity.")
  `PIDS_ASSERT(a_wr_in_list, mem_we_o |-> cnt_t'(mem_waddr_o) <= cnt_q, "Write beyond list end.")
  `PIDS_ASSERT(a_rw_apart, (mem_we_o && mem_re_o) |-> mem_waddr_o != mem_raddr_o, "Read and write collide.")
  `PIDS_ASSERT(a_cnt_steady, (state_q == SIdle) |=> $stable(cnt_q), "Count changed on accept.")

endmodule

[rtl/positional_insert_delete_store_top.sv]
// Top level of the positional insert/delete store.
//
// The block holds an ordered list of up to Capacity signed 32-bit entries.
// A request on the input channel (operation, position, value) inserts a
// value at a position, appends it at the end or deletes the entry at a
// position. Each request yields exactly one result on the output channel:
// status, removed value, entry count and the wrapping sum of the entries.
// Requests are handled one at a time. An insert at position p moves
// count - p entries, a delete at position p moves count - p - 1 entries and
// an append moves none. Each moved entry passes through the entry RAM, which
// moves one entry per cycle through its single read and single write port.
// The next request is accepted in the cycle after the result leaves the
// sequencer. A result waits in an output register, so the next request is
// accepted while the receiver stalls; that request finishes only once the
// register is free. Reset empties the list, clears the sum and drops the
// output valid; the RAM contents need no clearing.
`timescale 1ns / 1ps
`include "positional_insert_delete_store_top_defines.svh"
module positional_insert_delete_store_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  operation_i,
  input  logic [3:0]  position_i,
  input  logic signed [31:0] value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic signed [31:0] removed_value_o,
  output logic [4:0]  entry_count_o,
  output logic signed [31:0] total_o
);
  import pids_pkg::*;

  logic  res_valid;
  logic  res_ready;
  res_t  res;
  logic  mem_we;
  addr_t mem_waddr;
  val_t  mem_wdata;
  logic  mem_re;
  addr_t mem_raddr;
  val_t  mem_rdata;
  logic  out_valid_q;
  res_t  res_q;

  pids_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .operation_i (operation_i),
    .position_i  (position_i),
    .value_i     (value_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  pids_ram #(
    .Depth (Capacity),
    .Width (ValW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      if (res_ready) begin
        out_valid_q <= res_valid;
      end
      if (res_valid && res_ready) begin
        res_q <= res;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = res_q.status;
  assign removed_value_o = res_q.removed;
  assign entry_count_o   = res_q.count;
  assign total_o         = res_q.total;

  `PIDS_ASSERT_ALWAYS(a_rst_empty, !rst_ni |=> !out_valid_o, "Output valid during reset.")
  `PIDS_ASSERT(a_res_lands, (res_valid && res_ready) |=> out_valid_o, "Result lost in handoff.")
  `PIDS_ASSERT(a_busy_no_take, !in_ready_o |-> !(res_valid && in_ready_o), "Ready while finishing.")

endmodule

[dv/testbench.sv]
// Self-checking testbench for the positional insert/delete store, driven by a directed plan and random requests.
`timescale 1ns / 1ps
module testbench;
  import pids_pkg::*;

  localparam logic [1:0] OpUnused = 2'd3;
  localparam int unsigned RandomRequests = 1900;
  localparam int unsigned DrainCycles = 40;

  typedef struct {
    logic [1:0]  op;
    logic [3:0]  pos;
    logic [31:0] val;
    int unsigned reps;
    bit          typed;
    res_t        want;
  } plan_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic [1:0] operation_i = '0;
  logic [3:0] position_i = '0;
  logic signed [31:0] value_i = '0;
  logic out_ready_i = 1'b0;
  logic in_ready_o;
  logic out_valid_o;
  logic [1:0] status_o;
  logic signed [31:0] removed_value_o;
  logic [4:0] entry_count_o;
  logic signed [31:0] total_o;

  logic [31:0] list_entries [Capacity];
  int unsigned list_count = 0;
  logic [31:0] list_sum = '0;
  res_t pending_results [$];
  int unsigned mismatches = 0;
  int unsigned send_idle_pct = 27;
  int unsigned recv_idle_pct = 87;

  plan_row_t plan [21] = '{
    '{OpDelete, 4'd0, 32'h0, 1, 1'b1, '{StRange, 32'h0, 5'd0, 32'h0}},
    '{OpInsert, 4'd1, 32'h1234_5678, 1, 1'b1, '{StRange, 32'h0, 5'd0, 32'h0}},
    '{OpUnused, 4'd15, 32'hFFFF_FFFF, 1, 1'b1, '{StDone, 32'h0, 5'd0, 32'h0}},
    '{OpAppend, 4'd9, 32'h7FFF_FFFF, 1, 1'b1, '{StDone, 32'h0, 5'd1, 32'h7FFF_FFFF}},
    '{OpAppend, 4'd0, 32'h8000_0000, 1, 1'b1, '{StDone, 32'h0, 5'd2, 32'hFFFF_FFFF}},
    '{OpInsert, 4'd0, 32'h1, 1, 1'b1, '{StDone, 32'h0, 5'd3, 32'h0}},
    '{OpInsert, 4'd3, 32'h5, 1, 1'b1, '{StDone, 32'h0, 5'd4, 32'h5}},
    '{OpInsert, 4'd15, 32'h7, 1, 1'b1, '{StRange, 32'h0, 5'd4, 32'h5}},
    '{OpDelete, 4'd0, 32'h0, 1, 1'b1, '{StDone, 32'h1, 5'd3, 32'h4}},
    '{OpDelete, 4'd3, 32'h0, 1, 1'b1, '{StRange, 32'h0, 5'd3, 32'h4}},
    '{OpDelete, 4'd1, 32'hFFFF_FFFF, 1, 1'b1,
      '{StDone, 32'h8000_0000, 5'd2, 32'h8000_0004}},
    '{OpInsert, 4'd2, 32'h3, 14, 1'b0, '0},
    '{OpInsert, 4'd0, 32'h9, 1, 1'b1, '{StFull, 32'h0, 5'd16, 32'h8000_002E}},
    '{OpAppend, 4'd0, 32'h9, 1, 1'b1, '{StFull, 32'h0, 5'd16, 32'h8000_002E}},
    '{OpInsert, 4'd15, 32'h9, 1, 1'b1, '{StFull, 32'h0, 5'd16, 32'h8000_002E}},
    '{OpDelete, 4'd15, 32'h0, 1, 1'b0, '0},
    '{OpDelete, 4'd0, 32'h0, 1, 1'b0, '0},
    '{OpInsert, 4'd15, 32'h8000_0000, 1, 1'b0, '0},
    '{OpDelete, 4'd0, 32'h0, 14, 1'b0, '0},
    '{OpDelete, 4'd0, 32'h0, 1, 1'b1, '{StRange, 32'h0, 5'd0, 32'h0}},
    '{OpUnused, 4'd0, 32'h0, 1, 1'b0, '0}
  };

  positional_insert_delete_store_top u_dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .operation_i(operation_i),
    .position_i(position_i),
    .value_i(value_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .status_o(status_o),
    .removed_value_o(removed_value_o),
    .entry_count_o(entry_count_o),
    .total_o(total_o)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  function automatic res_t apply_list_op(logic [1:0] op, logic [3:0] pos, logic [31:0] val);
    res_t r;
    r = '{status: StDone, removed: '0, count: '0, total: '0};
    case (op) inside
      OpInsert, OpAppend: begin
        if (op == OpAppend) pos = 4'(list_count);
        if (list_count >= Capacity) begin
          r.status = StFull;
        end else if (op == OpInsert && int'(pos) > list_count) begin
          r.status = StRange;
        end else begin
          for (int i = list_count; i > int'(pos); i--) list_entries[i] = list_entries[i-1];
          list_entries[pos] = val;
          list_count++;
          list_sum += val;
        end
      end
      OpDelete: begin
        if (int'(pos) >= list_count) begin
          r.status = StRange;
        end else begin
          r.removed = list_entries[pos];
          for (int i = pos; i + 1 < list_count; i++) list_entries[i] = list_entries[i+1];
          list_count--;
          list_sum -= r.removed;
        end
      end
      default: ;
    endcase
    r.count = 5'(list_count);
    r.total = list_sum;
    return r;
  endfunction

  task automatic send_request(logic [1:0] op, logic [3:0] pos, logic [31:0] val,
                              bit typed, res_t want);
    res_t predicted;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    operation_i <= op;
    position_i <= pos;
    value_i <= val;
    do @(posedge clk_i); while (!in_ready_o);
    predicted = apply_list_op(op, pos, val);
    pending_results.push_back(typed ? want : predicted);
  endtask

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin : check_result
    res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: status %0d count %0d", status_o, entry_count_o);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          mismatches++;
        end
        if (removed_value_o !== want.removed) begin
          $error("removed_value: expected %h, got %h", want.removed, removed_value_o);
          mismatches++;
        end
        if (entry_count_o !== want.count) begin
          $error("entry_count: expected %0d, got %0d", want.count, entry_count_o);
          mismatches++;
        end
        if (total_o !== want.total) begin
          $error("total: expected %h, got %h", want.total, total_o);
          mismatches++;
        end
      end
    end
  end

  initial begin
    logic [1:0] op;
    logic [3:0] pos;
    logic [31:0] val;
    int unsigned target;
    int unsigned grow;
    target = 8;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (plan[k]) begin
      for (int j = 0; j < plan[k].reps; j++) begin
        send_request(plan[k].op, plan[k].pos, plan[k].val, plan[k].typed, plan[k].want);
      end
    end
    for (int n = 0; n < RandomRequests; n++) begin
      if (n == RandomRequests / 3) begin
        send_idle_pct = 87;
        recv_idle_pct = 27;
      end
      if (n == 2 * RandomRequests / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (n % 64 == 0) target = $urandom_range(Capacity);
      grow = (list_count < target) ? 75 : 25;
      if ($urandom_range(99) < 3) begin
        op = OpUnused;
      end else if ($urandom_range(99) < grow) begin
        op = $urandom_range(1) ? OpInsert : OpAppend;
      end else begin
        op = OpDelete;
      end
      if ($urandom_range(9) == 0) begin
        pos = 4'($urandom_range(15));
      end else if (op == OpDelete) begin
        pos = (list_count == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(list_count - 1));
      end else begin
        pos = 4'($urandom_range((list_count > 15) ? 15 : list_count));
      end
      case ($urandom_range(7))
        0: val = 32'h7FFF_FFFF;
        1: val = 32'h8000_0000;
        2: val = 32'h0;
        3: val = 32'hFFFF_FFFF;
        default: val = $urandom;
      endcase
      send_request(op, pos, val, 1'b0, '0);
    end
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
